[design/pae_pkg.sv]
// Package for the positional array editor.
// Holds the request kinds, result status codes, sequencer states and field widths.
// No dependencies.
package pae_pkg;

   localparam int KIND_W   = 3;
   localparam int POS_W    = 9;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 9;
   localparam int LENGTH_W = 9;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND       = 3'd0,
      KIND_INSERT       = 3'd1,
      KIND_DELETE_AT    = 3'd2,
      KIND_DELETE_MATCH = 3'd3,
      KIND_REPLACE      = 3'd4,
      KIND_READ         = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 2'd0,
      STATUS_BAD_POSITION = 2'd1,
      STATUS_FULL         = 2'd2,
      STATUS_NO_MATCH     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_POST,
      S_FINISH
   } state_type;

endpackage

[design/positional_array_editor.sv]
// Top level of the positional array editor: packed word store with a length register.
// Depends on pae_pkg and pae_ram.
//
// Usage:
//   The req_ channel carries one request beat: kind, position, value, new_value.
//   The rsp_ channel returns one beat per request: status, count, data_out,
//   length_now. Both channels use valid/ready.
//   Requests are handled one at a time; req_ready is high only while the
//   sequencer is idle. Append, an insert at the end, unused kinds, match
//   operations on an empty array and the error cases are settled in the
//   decode state and go straight to the finish state; a read fetches its
//   single word in the scan state. Insert and delete-at move one word per
//   cycle through the single RAM port pair, from the position to the end;
//   delete matches and replace matches walk the whole stored length.
//   The result sits in an output register, so a new request is taken while
//   the previous result still waits on a stalled receiver; the next result
//   is held in the sequencer until that register frees.
//   Reset empties the array (length zero) and drops any pending result; the
//   store itself is not cleared since words at or beyond the length are never read.
module positional_array_editor #(
   parameter int CAPACITY = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [pae_pkg::KIND_W-1:0]           req_kind,
   input  logic [pae_pkg::POS_W-1:0]            req_position,
   input  logic signed [pae_pkg::DATA_W-1:0]    req_value,
   input  logic signed [pae_pkg::DATA_W-1:0]    req_new_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pae_pkg::STATUS_W-1:0]         rsp_status,
   output logic [pae_pkg::COUNT_W-1:0]          rsp_count,
   output logic signed [pae_pkg::DATA_W-1:0]    rsp_data_out,
   output logic [pae_pkg::LENGTH_W-1:0]         rsp_length_now
);

   import pae_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = (LW > POS_W) ? LW : POS_W;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic signed [DATA_W-1:0] nval_ff, nval_in;
   logic [LW-1:0]            len_ff, len_in;
   logic [AW-1:0]            ptr_ff, ptr_in;
   logic [LW-1:0]            left_ff, left_in;
   logic                     dv_ff, dv_in;
   logic [AW-1:0]            dsrc_ff, dsrc_in;
   logic [LW-1:0]            wr_ff, wr_in;
   logic [LW-1:0]            cnt_ff, cnt_in;
   logic signed [DATA_W-1:0] dout_ff, dout_in;
   status_type               st_ff, st_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [LENGTH_W-1:0]      rsp_len_ff, rsp_len_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic [AW-1:0]     ram_raddr;
   logic [DATA_W-1:0] ram_rdata;

   logic [CW-1:0] posc;
   logic [CW-1:0] lenc;
   logic          bad_read;
   logic          bad_insert;
   logic          full;
   logic          is_match;
   logic          slot_free;

   assign posc       = CW'(pos_ff);
   assign lenc       = CW'(len_ff);
   assign bad_read   = posc >= lenc;
   assign bad_insert = posc > lenc;
   assign full       = len_ff == LW'(CAPACITY);
   assign is_match   = ram_rdata == val_ff;
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   pae_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (kind_ff)
               KIND_INSERT: begin
                  if (bad_insert || full || posc == lenc) begin
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               KIND_DELETE_AT, KIND_READ: begin
                  state_in = bad_read ? S_FINISH : S_SCAN;
               end
               KIND_DELETE_MATCH, KIND_REPLACE: begin
                  state_in = (len_ff == '0) ? S_FINISH : S_SCAN;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SCAN: begin
            if (left_ff == '0) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = state_ff == S_IDLE;
      kind_in       = kind_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      nval_in       = nval_ff;
      len_in        = len_ff;
      ptr_in        = ptr_ff;
      left_in       = left_ff;
      dv_in         = 1'b0;
      dsrc_in       = dsrc_ff;
      wr_in         = wr_ff;
      cnt_in        = cnt_ff;
      dout_in       = dout_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_len_in    = rsp_len_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = ptr_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in = kind_type'(req_kind);
               pos_in  = req_position;
               val_in  = req_value;
               nval_in = req_new_value;
               cnt_in  = '0;
               dout_in = '0;
               wr_in   = '0;
               st_in   = STATUS_OK;
            end
         end
         S_DECODE: begin
            case (kind_ff)
               KIND_APPEND: begin
                  if (full) begin
                     st_in = STATUS_FULL;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = AW'(len_ff);
                     ram_wdata = val_ff;
                     len_in    = LW'(len_ff + 1'b1);
                  end
               end
               KIND_INSERT: begin
                  if (bad_insert) begin
                     st_in = STATUS_BAD_POSITION;
                  end else if (full) begin
                     st_in = STATUS_FULL;
                  end else if (posc == lenc) begin
                     ram_we    = 1'b1;
                     ram_waddr = AW'(pos_ff);
                     ram_wdata = val_ff;
                     len_in    = LW'(len_ff + 1'b1);
                  end else begin
                     ptr_in  = AW'(len_ff - 1'b1);
                     left_in = LW'(len_ff - LW'(pos_ff));
                  end
               end
               KIND_DELETE_AT: begin
                  if (bad_read) begin
                     st_in = STATUS_BAD_POSITION;
                  end else begin
                     ptr_in  = AW'(pos_ff);
                     left_in = LW'(len_ff - LW'(pos_ff));
                  end
               end
               KIND_READ: begin
                  if (bad_read) begin
                     st_in = STATUS_BAD_POSITION;
                  end else begin
                     ptr_in  = AW'(pos_ff);
                     left_in = LW'(1);
                  end
               end
               KIND_DELETE_MATCH, KIND_REPLACE: begin
                  ptr_in  = '0;
                  left_in = len_ff;
                  if (len_ff == '0) begin
                     st_in = STATUS_NO_MATCH;
                  end
               end
               default: begin
                  st_in = STATUS_OK;
               end
            endcase
         end
         S_SCAN: begin
            if (left_ff != '0) begin
               dv_in   = 1'b1;
               dsrc_in = ptr_ff;
               ptr_in  = (kind_ff == KIND_INSERT) ? AW'(ptr_ff - 1'b1) : AW'(ptr_ff + 1'b1);
               left_in = LW'(left_ff - 1'b1);
            end
            if (dv_ff) begin
               case (kind_ff)
                  KIND_INSERT: begin
                     ram_we    = 1'b1;
                     ram_waddr = AW'(dsrc_ff + 1'b1);
                     ram_wdata = ram_rdata;
                  end
                  KIND_DELETE_AT: begin
                     if (dsrc_ff == AW'(pos_ff)) begin
                        dout_in = ram_rdata;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(dsrc_ff - 1'b1);
                        ram_wdata = ram_rdata;
                     end
                  end
                  KIND_DELETE_MATCH: begin
                     if (is_match) begin
                        cnt_in = LW'(cnt_ff + 1'b1);
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(wr_ff);
                        ram_wdata = ram_rdata;
                        wr_in     = LW'(wr_ff + 1'b1);
                     end
                  end
                  KIND_REPLACE: begin
                     if (is_match) begin
                        ram_we    = 1'b1;
                        ram_waddr = dsrc_ff;
                        ram_wdata = nval_ff;
                        cnt_in    = LW'(cnt_ff + 1'b1);
                     end
                  end
                  KIND_READ: begin
                     dout_in = ram_rdata;
                  end
                  default: begin
                     dout_in = dout_ff;
                  end
               endcase
            end
         end
         S_POST: begin
            case (kind_ff)
               KIND_INSERT: begin
                  ram_we    = 1'b1;
                  ram_waddr = AW'(pos_ff);
                  ram_wdata = val_ff;
                  len_in    = LW'(len_ff + 1'b1);
               end
               KIND_DELETE_AT: begin
                  len_in = LW'(len_ff - 1'b1);
               end
               KIND_DELETE_MATCH: begin
                  len_in = wr_ff;
                  if (cnt_ff == '0) begin
                     st_in = STATUS_NO_MATCH;
                  end
               end
               KIND_REPLACE: begin
                  if (cnt_ff == '0) begin
                     st_in = STATUS_NO_MATCH;
                  end
               end
               default: begin
                  len_in = len_ff;
               end
            endcase
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_count_in  = COUNT_W'(cnt_ff);
               rsp_data_in   = dout_ff;
               rsp_len_in    = LENGTH_W'(len_ff);
            end
         end
         default: begin
            dv_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      nval_ff       <= nval_in;
      ptr_ff        <= ptr_in;
      left_ff       <= left_in;
      dsrc_ff       <= dsrc_in;
      wr_ff         <= wr_in;
      cnt_ff        <= cnt_in;
      dout_ff       <= dout_in;
      st_ff         <= st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_length_now = rsp_len_ff;

endmodule

[design/pae_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used for the word store of the positional array editor; no dependencies.
module pae_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[verif/positional_array_editor_test.sv]
// Self-checking testbench for positional_array_editor: directed and random request beats
// against a queue-based predictor of the packed word store, with random idling on both sides.
// Depends on pae_pkg and the positional_array_editor RTL.
module positional_array_editor_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pae_pkg::*;

   localparam int CAPACITY       = 256;
   localparam int RESET_CYCLES   = 9;
   localparam int CYCLE_LIMIT    = 2_000_000;
   localparam int SETTLE_CYCLES  = CAPACITY + 16;
   localparam int RANDOM_ITEMS   = 400;
   localparam int PAUSE_INTERVAL = 100;

   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

   localparam int READY_ALWAYS = 0;
   localparam int READY_RANDOM = 1;
   localparam int READY_BURSTY = 2;

   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic [COUNT_W-1:0]       count;
      logic signed [DATA_W-1:0] data_out;
      logic [LENGTH_W-1:0]      length_now;
   } editor_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [KIND_W-1:0]          req_kind = '0;
   logic [POS_W-1:0]           req_position = '0;
   logic signed [DATA_W-1:0]   req_value = '0;
   logic signed [DATA_W-1:0]   req_new_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [COUNT_W-1:0]         rsp_count;
   logic signed [DATA_W-1:0]   rsp_data_out;
   logic [LENGTH_W-1:0]        rsp_length_now;

   logic signed [DATA_W-1:0]   stored_words[$];
   editor_result_type          pending_results[$];
   editor_result_type          head_result;
   int unsigned                failures = 0;
   int unsigned                cycle_count = 0;
   int unsigned                burst_left = 0;
   int unsigned                ready_mode = READY_ALWAYS;
   int unsigned                mode_left = 0;
   int unsigned                hold_left = 0;

   positional_array_editor #(.CAPACITY(CAPACITY)) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_position   (req_position),
      .req_value      (req_value),
      .req_new_value  (req_new_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_data_out   (rsp_data_out),
      .rsp_length_now (rsp_length_now)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("positional_array_editor: mismatch");
         $finish;
      end
   end

   // Update the word store for one request and return the result it causes.
   function automatic editor_result_type apply_request(logic [KIND_W-1:0] kind,
                                                       logic [POS_W-1:0] pos,
                                                       logic signed [DATA_W-1:0] val,
                                                       logic signed [DATA_W-1:0] nval);
      editor_result_type        res;
      logic signed [DATA_W-1:0] kept[$];
      int unsigned              len;
      int unsigned              hits;
      res.status   = STATUS_OK;
      res.data_out = '0;
      len  = stored_words.size();
      hits = 0;
      case (kind)
         KIND_APPEND: begin
            if (len >= CAPACITY) res.status = STATUS_FULL;
            else stored_words.push_back(val);
         end
         KIND_INSERT: begin
            if (pos > len) res.status = STATUS_BAD_POSITION;
            else if (len >= CAPACITY) res.status = STATUS_FULL;
            else stored_words.insert(int'(pos), val);
         end
         KIND_DELETE_AT: begin
            if (pos >= len) res.status = STATUS_BAD_POSITION;
            else begin
               res.data_out = stored_words[pos];
               stored_words.delete(int'(pos));
            end
         end
         KIND_DELETE_MATCH: begin
            foreach (stored_words[i]) begin
               if (stored_words[i] == val) hits++;
               else kept.push_back(stored_words[i]);
            end
            stored_words = kept;
            if (hits == 0) res.status = STATUS_NO_MATCH;
         end
         KIND_REPLACE: begin
            foreach (stored_words[i]) begin
               if (stored_words[i] == val) begin
                  stored_words[i] = nval;
                  hits++;
               end
            end
            if (hits == 0) res.status = STATUS_NO_MATCH;
         end
         KIND_READ: begin
            if (pos >= len) res.status = STATUS_BAD_POSITION;
            else res.data_out = stored_words[pos];
         end
         default: ;
      endcase
      res.count      = hits[COUNT_W-1:0];
      res.length_now = LENGTH_W'(stored_words.size());
      return res;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 3) == 0) return $urandom;
      case ($urandom_range(0, 5))
         0: return 32'sd0;
         1: return 32'sd1;
         2: return -32'sd1;
         3: return 32'sh7fff_ffff;
         4: return 32'sh8000_0000;
         default: return 32'sd5;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_match_value();
      if (stored_words.size() != 0 && $urandom_range(0, 1) == 0)
         return stored_words[$urandom_range(0, stored_words.size() - 1)];
      return pick_value();
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 8) return POS_W'($urandom_range(0, stored_words.size()));
      if (roll == 8) return POS_W'(stored_words.size() + $urandom_range(0, 3));
      return POS_W'($urandom_range(0, (1 << POS_W) - 1));
   endfunction

   // Present one request beat, hold it until accepted, then predict its result.
   task automatic send_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val,
                               logic signed [DATA_W-1:0] nval);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) == 0) gap = 0;
         else if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 300);
         else gap = $urandom_range(1, 4);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_position  <= pos;
      req_value     <= val;
      req_new_value <= nval;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(apply_request(kind, pos, val, nval));
   endtask

   // Hold off the sender until every outstanding result has been taken.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic send_random_request();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) send_request(KIND_APPEND, POS_W'($urandom), pick_value(), $urandom);
      else if (roll < 45) send_request(KIND_INSERT, pick_position(), pick_value(), $urandom);
      else if (roll < 60) send_request(KIND_DELETE_AT, pick_position(), $urandom, $urandom);
      else if (roll < 70)
         send_request(KIND_DELETE_MATCH, POS_W'($urandom), pick_match_value(), $urandom);
      else if (roll < 80)
         send_request(KIND_REPLACE, POS_W'($urandom), pick_match_value(), pick_value());
      else if (roll < 97) send_request(KIND_READ, pick_position(), $urandom, $urandom);
      else send_request($urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B,
                        POS_W'($urandom), $urandom, $urandom);
   endtask

   task automatic test_empty_array();
      send_request(KIND_READ, 9'd0, 32'sd0, 32'sd0);
      send_request(KIND_DELETE_AT, 9'd0, 32'sd0, 32'sd0);
      send_request(KIND_DELETE_AT, 9'd511, 32'sd0, 32'sd0);
      send_request(KIND_DELETE_MATCH, 9'd0, 32'sd0, 32'sd0);
      send_request(KIND_REPLACE, 9'd0, 32'sd0, 32'sd1);
      send_request(KIND_INSERT, 9'd1, 32'sd7, 32'sd0);
      send_request(KIND_INSERT, 9'd511, 32'sd7, 32'sd0);
      send_request(KIND_SPARE_A, 9'd0, 32'sd0, 32'sd0);
   endtask

   task automatic test_field_extremes();
      send_request(KIND_APPEND, 9'd0, 32'sh7fff_ffff, 32'sh8000_0000);
      send_request(KIND_APPEND, 9'd511, 32'sh8000_0000, 32'sh7fff_ffff);
      send_request(KIND_INSERT, 9'd0, 32'sd0, 32'sd0);
      send_request(KIND_INSERT, 9'd3, -32'sd1, 32'sd0);
      send_request(KIND_INSERT, 9'd5, 32'sd9, 32'sd0);
      for (int i = 0; i < 4; i++) send_request(KIND_READ, POS_W'(i), 32'sd0, 32'sd0);
      send_request(KIND_REPLACE, 9'd0, 32'sh8000_0000, 32'sh7fff_ffff);
      send_request(KIND_DELETE_MATCH, 9'd0, 32'sh7fff_ffff, 32'sd0);
      send_request(KIND_DELETE_AT, 9'd1, 32'sd0, 32'sd0);
      send_request(KIND_READ, 9'd256, 32'sd0, 32'sd0);
      send_request(KIND_DELETE_AT, 9'd511, 32'sd0, 32'sd0);
      send_request(KIND_SPARE_B, 9'd511, -32'sd1, -32'sd1);
      send_request(KIND_DELETE_MATCH, 9'd0, 32'sd0, 32'sd0);
   endtask

   task automatic test_fill_to_capacity();
      while (stored_words.size() < CAPACITY) begin
         if ($urandom_range(0, 1) == 0)
            send_request(KIND_APPEND, POS_W'($urandom), pick_value(), $urandom);
         else send_request(KIND_INSERT, POS_W'($urandom_range(0, stored_words.size())),
                           pick_value(), $urandom);
      end
      wait_for_results();
      send_request(KIND_APPEND, 9'd0, 32'sd3, 32'sd0);
      send_request(KIND_INSERT, 9'd0, 32'sd3, 32'sd0);
      send_request(KIND_INSERT, 9'd256, 32'sd3, 32'sd0);
      send_request(KIND_INSERT, 9'd257, 32'sd3, 32'sd0);
      send_request(KIND_READ, 9'd255, 32'sd0, 32'sd0);
      send_request(KIND_READ, 9'd256, 32'sd0, 32'sd0);
      send_request(KIND_REPLACE, 9'd0, pick_match_value(), pick_value());
      send_request(KIND_DELETE_AT, 9'd255, 32'sd0, 32'sd0);
      send_request(KIND_APPEND, 9'd0, pick_value(), 32'sd0);
      send_request(KIND_DELETE_AT, 9'd0, 32'sd0, 32'sd0);
      for (int i = 0; i < 4; i++) send_request(KIND_DELETE_MATCH, 9'd0, pick_value(), 32'sd0);
   endtask

   task automatic test_random_mix();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PAUSE_INTERVAL == PAUSE_INTERVAL / 2) wait_for_results();
         send_random_request();
      end
   endtask

   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode = $urandom_range(READY_ALWAYS, READY_BURSTY);
         mode_left  = $urandom_range(32, 256);
      end else begin
         mode_left--;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (hold_left != 0) hold_left--;
            else begin
               rsp_ready <= ~rsp_ready;
               hold_left = rsp_ready ? $urandom_range(1, 30) : $urandom_range(0, 4);
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result beat: status %0d length_now %0d",
                   rsp_status, rsp_length_now);
            failures++;
         end else begin
            head_result = pending_results.pop_front();
            if (rsp_status !== head_result.status) begin
               $error("status: expected %0d, actual %0d", head_result.status, rsp_status);
               failures++;
            end
            if (rsp_count !== head_result.count) begin
               $error("count: expected %0d, actual %0d", head_result.count, rsp_count);
               failures++;
            end
            if (rsp_data_out !== head_result.data_out) begin
               $error("data_out: expected %0d, actual %0d", head_result.data_out, rsp_data_out);
               failures++;
            end
            if (rsp_length_now !== head_result.length_now) begin
               $error("length_now: expected %0d, actual %0d",
                      head_result.length_now, rsp_length_now);
               failures++;
            end
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_empty_array();
      test_field_extremes();
      test_fill_to_capacity();
      test_random_mix();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("positional_array_editor: match");
      end else begin
         $display("positional_array_editor: mismatch");
      end
      $finish;
   end

endmodule
